/* rtl/atbq_pkg.sv */
// Shared constants and helpers for the adaptive two-bit quantizer.
package atbq_pkg;

    localparam int SAMPLE_BITS_DEF   = 12;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int SHIFT_BITS = 5;
    localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = 5'd10;
    localparam logic [SHIFT_BITS-1:0] SHIFT_MIN   = 5'd4;
    localparam logic [SHIFT_BITS-1:0] SHIFT_MAX   = 5'd16;

    localparam int LEVEL_BITS = 3;
    localparam logic signed [LEVEL_BITS-1:0] LEVEL_POS1 = 3'sd1;
    localparam logic signed [LEVEL_BITS-1:0] LEVEL_POS3 = 3'sd3;
    localparam logic signed [LEVEL_BITS-1:0] LEVEL_NEG1 = -3'sd1;
    localparam logic signed [LEVEL_BITS-1:0] LEVEL_NEG3 = -3'sd3;

    // The register keeps any written value; only the shift in use is clamped.
    function automatic logic [SHIFT_BITS-1:0] clamp_shift(input logic [SHIFT_BITS-1:0] raw);
        logic [SHIFT_BITS-1:0] s;
        s = raw;
        if (raw < SHIFT_MIN)
        begin
            s = SHIFT_MIN;
        end
        else if (raw > SHIFT_MAX)
        begin
            s = SHIFT_MAX;
        end
        return s;
    endfunction

endpackage

/* rtl/atbq_mean_stage.sv */
// Running mean update and deviation magnitude of the new sample.
module atbq_mean_stage #(
    parameter int SAMPLE_BITS   = atbq_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = atbq_pkg::FRACTION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [atbq_pkg::SHIFT_BITS-1:0]     shift,
    input  logic                                up_valid,
    output logic                                up_ready,
    input  logic signed [SAMPLE_BITS-1:0]       up_sample,
    output logic                                dn_valid,
    input  logic                                dn_ready,
    output logic [SAMPLE_BITS+FRACTION_BITS-1:0] dn_dev_mag,
    output logic                                dn_dev_ovf,
    output logic signed [SAMPLE_BITS-1:0]       dn_sample
);
    import atbq_pkg::*;

    localparam int MEAN_BITS = SAMPLE_BITS + FRACTION_BITS;
    localparam logic [63:0] MAG_LIMIT = 64'h1_0000_0000;

    logic signed [MEAN_BITS-1:0] mean_reg;
    logic signed [MEAN_BITS-1:0] mean_next;
    logic                        valid_reg;
    logic [MEAN_BITS-1:0]        dev_mag_reg;
    logic                        dev_ovf_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;

    logic signed [MEAN_BITS-1:0] xs;
    logic signed [MEAN_BITS:0]   xs_w;
    logic signed [MEAN_BITS:0]   diff;
    logic signed [MEAN_BITS:0]   step;
    logic signed [MEAN_BITS:0]   sum;
    logic signed [MEAN_BITS:0]   dev;
    logic [MEAN_BITS:0]          dev_abs;
    logic [MEAN_BITS-1:0]        dev_mag;
    logic                        dev_ovf;
    logic                        fire;

    assign xs   = {up_sample, {FRACTION_BITS{1'b0}}};
    assign xs_w = (MEAN_BITS+1)'(xs);
    assign diff = xs_w - (MEAN_BITS+1)'(mean_reg);
    assign step = diff >>> shift;
    assign sum  = (MEAN_BITS+1)'(mean_reg) + step;

    always_comb
    begin
        if (sum[MEAN_BITS] != sum[MEAN_BITS-1])
        begin
            mean_next = sum[MEAN_BITS] ? {1'b1, {(MEAN_BITS-1){1'b0}}}
                                       : {1'b0, {(MEAN_BITS-1){1'b1}}};
        end
        else
        begin
            mean_next = MEAN_BITS'(sum);
        end
    end

    // The deviation is taken against the freshly updated mean.
    assign dev     = xs_w - (MEAN_BITS+1)'(mean_next);
    assign dev_abs = dev[MEAN_BITS] ? (MEAN_BITS+1)'(-dev) : (MEAN_BITS+1)'(dev);
    assign dev_mag = MEAN_BITS'(dev_abs);
    assign dev_ovf = (64'(dev_abs) >= MAG_LIMIT);

    assign up_ready = !valid_reg || dn_ready;
    assign fire     = up_valid && up_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (up_ready)
            begin
                valid_reg <= up_valid;
            end
            if (fire)
            begin
                mean_reg <= mean_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            dev_mag_reg <= dev_mag;
            dev_ovf_reg <= dev_ovf;
            sample_reg  <= up_sample;
        end
    end

    assign dn_valid   = valid_reg;
    assign dn_dev_mag = dev_mag_reg;
    assign dn_dev_ovf = dev_ovf_reg;
    assign dn_sample  = sample_reg;

endmodule

/* rtl/atbq_square_stage.sv */
// Squares of the deviation (scaled and saturated) and of the sample.
module atbq_square_stage #(
    parameter int SAMPLE_BITS   = atbq_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = atbq_pkg::FRACTION_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    up_valid,
    output logic                                    up_ready,
    input  logic [SAMPLE_BITS+FRACTION_BITS-1:0]    up_dev_mag,
    input  logic                                    up_dev_ovf,
    input  logic signed [SAMPLE_BITS-1:0]           up_sample,
    output logic                                    dn_valid,
    input  logic                                    dn_ready,
    output logic [2*SAMPLE_BITS+FRACTION_BITS-1:0]  dn_dev_sq,
    output logic [2*SAMPLE_BITS-2:0]                dn_sample_sq,
    output logic                                    dn_negative
);
    import atbq_pkg::*;

    localparam int MEAN_BITS = SAMPLE_BITS + FRACTION_BITS;
    localparam int VAR_BITS  = 2 * SAMPLE_BITS + FRACTION_BITS;
    localparam int SQ_BITS   = (MEAN_BITS > 32) ? 32 : MEAN_BITS;
    localparam int XSQ_BITS  = 2 * SAMPLE_BITS - 1;
    localparam logic [63:0] VAR_MAX64 = (64'd1 << VAR_BITS) - 64'd1;

    logic [SQ_BITS-1:0]       op;
    logic [2*SQ_BITS-1:0]     prod;
    logic [2*SQ_BITS-1:0]     prod_scaled;
    logic [VAR_BITS-1:0]      dev_sq;
    logic [SAMPLE_BITS-1:0]   sample_abs;
    logic [2*SAMPLE_BITS-1:0] sample_prod;
    logic                     fire;

    logic                     valid_reg;
    logic [VAR_BITS-1:0]      dev_sq_reg;
    logic [XSQ_BITS-1:0]      sample_sq_reg;
    logic                     negative_reg;

    // Magnitudes of 2^32 and above saturate, so only the low 32 bits are multiplied.
    assign op          = SQ_BITS'(up_dev_mag);
    assign prod        = op * op;
    assign prod_scaled = prod >> FRACTION_BITS;

    always_comb
    begin
        if (up_dev_ovf || (64'(prod_scaled) > VAR_MAX64))
        begin
            dev_sq = {VAR_BITS{1'b1}};
        end
        else
        begin
            dev_sq = VAR_BITS'(prod_scaled);
        end
    end

    assign sample_abs  = up_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-up_sample)
                                                  : SAMPLE_BITS'(up_sample);
    assign sample_prod = sample_abs * sample_abs;

    assign up_ready = !valid_reg || dn_ready;
    assign fire     = up_valid && up_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            dev_sq_reg    <= dev_sq;
            sample_sq_reg <= XSQ_BITS'(sample_prod);
            negative_reg  <= up_sample[SAMPLE_BITS-1];
        end
    end

    assign dn_valid     = valid_reg;
    assign dn_dev_sq    = dev_sq_reg;
    assign dn_sample_sq = sample_sq_reg;
    assign dn_negative  = negative_reg;

endmodule

/* rtl/atbq_var_stage.sv */
// Running variance update, level decision and result register.
module atbq_var_stage #(
    parameter int SAMPLE_BITS   = atbq_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = atbq_pkg::FRACTION_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic [atbq_pkg::SHIFT_BITS-1:0]         shift,
    input  logic                                    up_valid,
    output logic                                    up_ready,
    input  logic [2*SAMPLE_BITS+FRACTION_BITS-1:0]  up_dev_sq,
    input  logic [2*SAMPLE_BITS-2:0]                up_sample_sq,
    input  logic                                    up_negative,
    output logic                                    dn_valid,
    input  logic                                    dn_ready,
    output logic signed [atbq_pkg::LEVEL_BITS-1:0]  dn_level
);
    import atbq_pkg::*;

    localparam int VAR_BITS = 2 * SAMPLE_BITS + FRACTION_BITS;

    logic [VAR_BITS-1:0]          var_reg;
    logic [VAR_BITS-1:0]          var_next;
    logic                         valid_reg;
    logic signed [LEVEL_BITS-1:0] level_reg;

    logic signed [VAR_BITS:0]     diff;
    logic signed [VAR_BITS:0]     step;
    logic signed [VAR_BITS:0]     sum;
    logic [VAR_BITS-1:0]          sample_sq_scaled;
    logic                         below_var;
    logic signed [LEVEL_BITS-1:0] level;
    logic                         fire;

    assign diff = $signed({1'b0, up_dev_sq}) - $signed({1'b0, var_reg});
    assign step = diff >>> shift;
    assign sum  = $signed({1'b0, var_reg}) + step;

    // The result lies between the old variance and the new square, so only
    // the low side needs a clamp.
    assign var_next = sum[VAR_BITS] ? '0 : VAR_BITS'(sum);

    // x squared against the variance stands in for |x| against the deviation.
    assign sample_sq_scaled = VAR_BITS'(up_sample_sq) << FRACTION_BITS;
    assign below_var        = (sample_sq_scaled < var_next);

    always_comb
    begin
        case ({up_negative, below_var})
            2'b00:   level = LEVEL_POS3;
            2'b01:   level = LEVEL_POS1;
            2'b10:   level = LEVEL_NEG3;
            2'b11:   level = LEVEL_NEG1;
            default: level = LEVEL_POS3;
        endcase
    end

    assign up_ready = !valid_reg || dn_ready;
    assign fire     = up_valid && up_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            var_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (up_ready)
            begin
                valid_reg <= up_valid;
            end
            if (fire)
            begin
                var_reg <= var_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            level_reg <= level;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_level = level_reg;

endmodule

/* rtl/adaptive_two_bit_quantizer.sv */
// Top level of the adaptive two-bit quantizer: input register, shift register, three stages.
//
//   Channel          Signals                               Transfer when
//   sample in        sample, sample_valid, sample_stall    sample_valid && !sample_stall
//   level out        level, level_valid, level_stall       level_valid && !level_stall
//   shift config     smoothing_shift, smoothing_shift_we   smoothing_shift_we
//
// One sample is taken every cycle while sample_stall is low. The mean loop closes in the
// first stage and the variance loop in the last, with the deviation multiplier registered
// between them; the input register and each stage register lie between sample and level.
// Reset clears the mean, the variance and all valid bits, and sets the shift to 10.
// A stall on the output backs up stage by stage; empty stages still fill.
module adaptive_two_bit_quantizer #(
    parameter int SAMPLE_BITS   = atbq_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = atbq_pkg::FRACTION_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   smoothing_shift_we,
    input  logic [atbq_pkg::SHIFT_BITS-1:0]        smoothing_shift,
    input  logic                                   sample_valid,
    output logic                                   sample_stall,
    input  logic signed [SAMPLE_BITS-1:0]          sample,
    output logic                                   level_valid,
    input  logic                                   level_stall,
    output logic signed [atbq_pkg::LEVEL_BITS-1:0] level
);
    import atbq_pkg::*;

    localparam int MEAN_BITS = SAMPLE_BITS + FRACTION_BITS;
    localparam int VAR_BITS  = 2 * SAMPLE_BITS + FRACTION_BITS;

    logic [SHIFT_BITS-1:0]         shift_reg;
    logic [SHIFT_BITS-1:0]         shift_eff;
    logic                          in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;
    logic                          in_ready;

    logic                          m_ready;
    logic                          m_valid;
    logic [MEAN_BITS-1:0]          m_dev_mag;
    logic                          m_dev_ovf;
    logic signed [SAMPLE_BITS-1:0] m_sample;

    logic                          q_ready;
    logic                          q_valid;
    logic [VAR_BITS-1:0]           q_dev_sq;
    logic [2*SAMPLE_BITS-2:0]      q_sample_sq;
    logic                          q_negative;

    logic                          v_ready;
    logic                          v_ready_chain;

    assign shift_eff    = clamp_shift(shift_reg);
    assign in_ready     = !in_valid_reg || m_ready;
    assign sample_stall = !in_ready;
    assign v_ready      = !level_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg    <= SHIFT_RESET;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            if (smoothing_shift_we)
            begin
                shift_reg <= smoothing_shift;
            end
            if (in_ready)
            begin
                in_valid_reg <= sample_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && sample_valid)
        begin
            in_sample_reg <= sample;
        end
    end

    atbq_mean_stage #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mean (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift      (shift_eff),
        .up_valid   (in_valid_reg),
        .up_ready   (m_ready),
        .up_sample  (in_sample_reg),
        .dn_valid   (m_valid),
        .dn_ready   (q_ready),
        .dn_dev_mag (m_dev_mag),
        .dn_dev_ovf (m_dev_ovf),
        .dn_sample  (m_sample)
    );

    atbq_square_stage #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_square (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (m_valid),
        .up_ready     (q_ready),
        .up_dev_mag   (m_dev_mag),
        .up_dev_ovf   (m_dev_ovf),
        .up_sample    (m_sample),
        .dn_valid     (q_valid),
        .dn_ready     (v_ready_chain),
        .dn_dev_sq    (q_dev_sq),
        .dn_sample_sq (q_sample_sq),
        .dn_negative  (q_negative)
    );

    atbq_var_stage #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_var (
        .clk          (clk),
        .rst_n        (rst_n),
        .shift        (shift_eff),
        .up_valid     (q_valid),
        .up_ready     (v_ready_chain),
        .up_dev_sq    (q_dev_sq),
        .up_sample_sq (q_sample_sq),
        .up_negative  (q_negative),
        .dn_valid     (level_valid),
        .dn_ready     (v_ready),
        .dn_level     (level)
    );

endmodule
